// ----- rtl/rcfd_pkg.sv -----
`timescale 1ns / 1ps

package rcfd_pkg;

  localparam int MAX_FRAME_BYTES = 32;
  localparam int FRAME_LEN       = 16;
  localparam int STICK_W         = 11;

  localparam logic [STICK_W-1:0] STICK_LOW_RESET  = 11'd364;
  localparam logic [STICK_W-1:0] STICK_HIGH_RESET = 11'd1684;
  localparam logic [STICK_W-1:0] STICK_CENTRE     = 11'd1024;

  localparam logic [1:0] SW_MIDDLE = 2'd3;
  localparam logic [1:0] SW_UP     = 2'd1;
  localparam logic [1:0] SW_DOWN   = 2'd2;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_LEAVE = 2'd1,
    EV_RETURN = 2'd2
  } sw_event_t;

  typedef enum logic [1:0] {
    MODE_BYTE  = 2'd0,
    MODE_GAP   = 2'd1,
    MODE_QUERY = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    ST_BYTE      = 4'd0,
    ST_FRAME_OK  = 4'd1,
    ST_REJECTED  = 4'd2,
    ST_NO_ACTION = 4'd3,
    ST_MID_UP    = 4'd4,
    ST_MID_DOWN  = 4'd5,
    ST_UP_MID    = 4'd6,
    ST_DOWN_MID  = 4'd7,
    ST_PRESS     = 4'd8,
    ST_RELEASE   = 4'd9
  } status_t;

  localparam logic [0:0] REG_STICK_LOW  = 1'd0;
  localparam logic [0:0] REG_STICK_HIGH = 1'd1;

  localparam logic [4:0] TGT_KEY_FIRST = 5'd4;
  localparam logic [4:0] TGT_KEY_LAST  = 5'd19;
  localparam logic [4:0] TGT_LEFT_BTN  = 5'd20;
  localparam logic [4:0] TGT_RIGHT_BTN = 5'd21;

endpackage

// ----- rtl/rcfd_in_if.sv -----
`timescale 1ns / 1ps

interface rcfd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  logic [4:0] query_target;

  modport source (output valid, mode, data_byte, query_target, input ready);
  modport sink (input valid, mode, data_byte, query_target, output ready);
endinterface

// ----- rtl/rcfd_out_if.sv -----
`timescale 1ns / 1ps

interface rcfd_out_if;
  logic               valid;
  logic               ready;
  logic        [3:0]  status;
  logic        [10:0] stick_0;
  logic        [10:0] stick_1;
  logic        [10:0] stick_2;
  logic        [10:0] stick_3;
  logic        [1:0]  switch_1;
  logic        [1:0]  switch_2;
  logic signed [15:0] mouse_x;
  logic signed [15:0] mouse_y;
  logic signed [15:0] mouse_z;
  logic        [1:0]  mouse_buttons;
  logic        [15:0] key_bits;

  modport source (output valid, status, stick_0, stick_1, stick_2, stick_3, switch_1, switch_2,
                  mouse_x, mouse_y, mouse_z, mouse_buttons, key_bits, input ready);
  modport sink (input valid, status, stick_0, stick_1, stick_2, stick_3, switch_1, switch_2,
                mouse_x, mouse_y, mouse_z, mouse_buttons, key_bits, output ready);
endinterface

// ----- rtl/rc_frame_decoder_with_events_core.sv -----
`timescale 1ns / 1ps

// Remote-receiver frame decoder. Feed frame bytes (mode 0), then an idle-gap
// marker (mode 1) to decode and check the first 16 bytes; mode 2 reads and
// clears one pending switch, key or button event. Every transaction yields one
// result in the following cycle, and a new transaction is taken every cycle: the
// block holds a single result register, refilled in the cycle it is taken, so
// the rate is one item per clock while the result side keeps up. The state
// update and result for an item are formed combinationally from the frame store
// and the decoded state registers. Stick limits may be changed only while the
// block is idle.
module rc_frame_decoder_with_events_core #(
  parameter int MAX_FRAME_BYTES = rcfd_pkg::MAX_FRAME_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  rcfd_in_if.sink                       item,
  rcfd_out_if.source                    res,
  input  logic                          cfg_write,
  input  logic [0:0]                    cfg_index,
  input  logic [rcfd_pkg::STICK_W-1:0]  cfg_data
);

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int SW    = rcfd_pkg::STICK_W;

  logic [7:0]       frame_store [rcfd_pkg::FRAME_LEN];
  logic [CNT_W-1:0] byte_count;
  logic [SW-1:0]    stick_low;
  logic [SW-1:0]    stick_high;
  logic [SW-1:0]    stick [4];
  logic [1:0]       sw_pos [2];
  logic [15:0]      mouse [3];
  logic [1:0]       buttons;
  logic [15:0]      keys;
  logic [1:0]       sw_ev [2];
  logic [1:0]       sw_origin [2];
  logic [15:0]      key_changes;
  logic [1:0]       button_changes;
  logic             out_valid;
  logic [3:0]       status;

  logic [SW-1:0]    stick_next [4];
  logic [1:0]       sw_pos_next [2];
  logic [15:0]      mouse_next [3];
  logic [1:0]       buttons_next;
  logic [15:0]      keys_next;
  logic [1:0]       sw_ev_next [2];
  logic [1:0]       sw_origin_next [2];
  logic [15:0]      key_changes_next;
  logic [1:0]       button_changes_next;
  logic [3:0]       status_next;
  logic [CNT_W-1:0] byte_count_next;

  logic             accept;
  logic             full;
  logic [SW-1:0]    ch [4];
  logic [1:0]       s [2];
  logic             frame_ok;
  logic [1:0]       nb;
  logic [15:0]      nk;
  logic             qsw;
  logic [3:0]       kidx;
  logic [4:0]       koff;
  logic [1:0]       bmask;

  assign item.ready = !out_valid || res.ready;
  assign accept     = item.valid && item.ready;
  assign full       = byte_count >= CNT_W'(rcfd_pkg::FRAME_LEN);

  // bit unpacking of the 11-bit sticks and the switch pair
  assign ch[0] = {frame_store[1][2:0], frame_store[0]};
  assign ch[1] = {frame_store[2][5:0], frame_store[1][7:3]};
  assign ch[2] = {frame_store[4][0], frame_store[3], frame_store[2][7:6]};
  assign ch[3] = {frame_store[5][3:0], frame_store[4][7:1]};
  assign s[0]  = frame_store[5][7:6];
  assign s[1]  = frame_store[5][5:4];
  assign nb    = {frame_store[12][0], frame_store[13][0]};
  assign nk    = {frame_store[15], frame_store[14]};

  assign qsw   = item.query_target[1];
  assign koff  = item.query_target - rcfd_pkg::TGT_KEY_FIRST;
  assign kidx  = koff[3:0];
  assign bmask = (item.query_target == rcfd_pkg::TGT_LEFT_BTN) ? 2'b10 : 2'b01;

  always_comb begin
    frame_ok = full && s[0] != 2'd0 && s[1] != 2'd0
               && frame_store[12] <= 8'd1 && frame_store[13] <= 8'd1;
    for (int i = 0; i < 4; i++) begin
      frame_ok = frame_ok && ch[i] > stick_low && ch[i] < stick_high;
    end
  end

  always_comb begin
    stick_next          = stick;
    sw_pos_next         = sw_pos;
    mouse_next          = mouse;
    buttons_next        = buttons;
    keys_next           = keys;
    sw_ev_next          = sw_ev;
    sw_origin_next      = sw_origin;
    key_changes_next    = key_changes;
    button_changes_next = button_changes;
    byte_count_next     = byte_count;
    status_next         = rcfd_pkg::ST_NO_ACTION;

    case (item.mode)
      rcfd_pkg::MODE_BYTE: begin
        if (byte_count < CNT_W'(MAX_FRAME_BYTES)) begin
          byte_count_next = byte_count + 1'b1;
        end
        status_next = rcfd_pkg::ST_BYTE;
      end
      rcfd_pkg::MODE_GAP: begin
        byte_count_next = '0;
        if (frame_ok) begin
          status_next = rcfd_pkg::ST_FRAME_OK;
          for (int i = 0; i < 2; i++) begin
            if (sw_pos[i] == rcfd_pkg::SW_MIDDLE && s[i] != rcfd_pkg::SW_MIDDLE) begin
              sw_ev_next[i] = rcfd_pkg::EV_LEAVE;
            end else if (sw_pos[i] != rcfd_pkg::SW_MIDDLE && s[i] == rcfd_pkg::SW_MIDDLE) begin
              sw_ev_next[i]     = rcfd_pkg::EV_RETURN;
              sw_origin_next[i] = sw_pos[i];
            end
            sw_pos_next[i] = s[i];
          end
          stick_next          = ch;
          mouse_next[0]       = {frame_store[7], frame_store[6]};
          mouse_next[1]       = {frame_store[9], frame_store[8]};
          mouse_next[2]       = {frame_store[11], frame_store[10]};
          button_changes_next = button_changes | (buttons ^ nb);
          buttons_next        = nb;
          key_changes_next    = key_changes | (keys ^ nk);
          keys_next           = nk;
        end else begin
          status_next = rcfd_pkg::ST_REJECTED;
        end
      end
      rcfd_pkg::MODE_QUERY: begin
        if (item.query_target < rcfd_pkg::TGT_KEY_FIRST) begin
          if (!item.query_target[0]) begin
            if (sw_ev[qsw] == rcfd_pkg::EV_LEAVE) begin
              if (sw_pos[qsw] == rcfd_pkg::SW_UP) begin
                sw_ev_next[qsw] = rcfd_pkg::EV_NONE;
                status_next     = rcfd_pkg::ST_MID_UP;
              end else if (sw_pos[qsw] == rcfd_pkg::SW_DOWN) begin
                sw_ev_next[qsw] = rcfd_pkg::EV_NONE;
                status_next     = rcfd_pkg::ST_MID_DOWN;
              end
            end
          end else if (sw_ev[qsw] == rcfd_pkg::EV_RETURN) begin
            if (sw_origin[qsw] == rcfd_pkg::SW_UP) begin
              sw_ev_next[qsw]     = rcfd_pkg::EV_NONE;
              sw_origin_next[qsw] = 2'd0;
              status_next         = rcfd_pkg::ST_UP_MID;
            end else if (sw_origin[qsw] == rcfd_pkg::SW_DOWN) begin
              sw_ev_next[qsw]     = rcfd_pkg::EV_NONE;
              sw_origin_next[qsw] = 2'd0;
              status_next         = rcfd_pkg::ST_DOWN_MID;
            end
          end
        end else if (item.query_target <= rcfd_pkg::TGT_KEY_LAST) begin
          if (key_changes[kidx]) begin
            key_changes_next[kidx] = 1'b0;
            status_next = keys[kidx] ? rcfd_pkg::ST_PRESS : rcfd_pkg::ST_RELEASE;
          end
        end else if (item.query_target <= rcfd_pkg::TGT_RIGHT_BTN) begin
          if ((button_changes & bmask) != 2'b00) begin
            button_changes_next = button_changes & ~bmask;
            status_next = ((buttons & bmask) != 2'b00) ? rcfd_pkg::ST_PRESS
                                                        : rcfd_pkg::ST_RELEASE;
          end
        end
      end
      default: begin
        status_next = rcfd_pkg::ST_NO_ACTION;
      end
    endcase
  end

  // frame store: no reset, only ever read after sixteen fresh writes
  always_ff @(posedge clk) begin
    if (accept && item.mode == rcfd_pkg::MODE_BYTE && !full) begin
      frame_store[byte_count[3:0]] <= item.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stick_low      <= rcfd_pkg::STICK_LOW_RESET;
      stick_high     <= rcfd_pkg::STICK_HIGH_RESET;
      byte_count     <= '0;
      for (int i = 0; i < 4; i++) stick[i] <= rcfd_pkg::STICK_CENTRE;
      for (int i = 0; i < 2; i++) begin
        sw_pos[i]    <= rcfd_pkg::SW_MIDDLE;
        sw_ev[i]     <= rcfd_pkg::EV_NONE;
        sw_origin[i] <= 2'd0;
      end
      for (int i = 0; i < 3; i++) mouse[i] <= '0;
      buttons        <= '0;
      keys           <= '0;
      key_changes    <= '0;
      button_changes <= '0;
      out_valid      <= 1'b0;
      status         <= rcfd_pkg::ST_NO_ACTION;
    end else begin
      if (cfg_write) begin
        if (cfg_index == rcfd_pkg::REG_STICK_LOW) stick_low <= cfg_data;
        else stick_high <= cfg_data;
      end
      if (accept) begin
        stick          <= stick_next;
        sw_pos         <= sw_pos_next;
        mouse          <= mouse_next;
        buttons        <= buttons_next;
        keys           <= keys_next;
        sw_ev          <= sw_ev_next;
        sw_origin      <= sw_origin_next;
        key_changes    <= key_changes_next;
        button_changes <= button_changes_next;
        byte_count     <= byte_count_next;
        status         <= status_next;
        out_valid      <= 1'b1;
      end else if (res.ready) begin
        out_valid      <= 1'b0;
      end
    end
  end

  // state only moves when a new result is loaded, so it doubles as the payload
  assign res.valid         = out_valid;
  assign res.status        = status;
  assign res.stick_0       = stick[0];
  assign res.stick_1       = stick[1];
  assign res.stick_2       = stick[2];
  assign res.stick_3       = stick[3];
  assign res.switch_1      = sw_pos[0];
  assign res.switch_2      = sw_pos[1];
  assign res.mouse_x       = mouse[0];
  assign res.mouse_y       = mouse[1];
  assign res.mouse_z       = mouse[2];
  assign res.mouse_buttons = buttons;
  assign res.key_bits      = keys;

endmodule
